// File: rtl/core/decp_pkg.sv
// Shared types, character codes and the character classifier for the
// ASCII decimal parser. No dependencies.
package decp_pkg;

  // ASCII codes the parser cares about
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam int unsigned NUM_W = 64;

  // parse phase, one-hot
  typedef enum logic [3:0] {
    PH_LEAD   = 4'b0001,
    PH_DIGITS = 4'b0010,
    PH_TRAIL  = 4'b0100,
    PH_FAIL   = 4'b1000
  } phase_e;

  // decoded view of one character
  typedef struct packed {
    logic       is_term;
    logic       is_blank;
    logic       is_digit;
    logic [3:0] digit;
  } char_class_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    logic [7:0]  off;
    off        = c - CHAR_ZERO;
    r.is_term  = (c == CHAR_NUL);
    r.is_blank = (c == CHAR_SPACE) || (c == CHAR_TAB);
    r.is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    r.digit    = off[3:0];
    return r;
  endfunction

endpackage

// File: rtl/core/decp_in_stage.sv
// Input register for the decimal parser: holds one character until the
// parse stage takes it. Depends on nothing.
module decp_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] char_i,
  output logic       valid_o,
  output logic [7:0] char_o,
  input  logic       take_i
);

  logic       valid_q, valid_d;
  logic [7:0] char_q;
  logic       load;

  // free when empty or when the held character leaves this cycle
  assign ready_o = !valid_q || take_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_i;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;

endmodule

// File: rtl/core/decp_parse.sv
// Parse stage: phase machine and 64-bit accumulator, updated once per
// character. Depends on decp_pkg.
module decp_parse (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [7:0]                char_i,
  input  logic                      out_space_i,
  output logic                      take_o,
  output logic                      res_valid_o,
  output logic                      res_ok_o,
  output logic [decp_pkg::NUM_W-1:0] res_number_o
);
  import decp_pkg::*;

  phase_e             phase_q, phase_d;
  logic [NUM_W-1:0]   acc_q, acc_d;
  char_class_t        cls;
  logic [NUM_W+3:0]   mac;
  logic               ovf;
  logic               good;

  assign cls = classify(char_i);

  // terminator needs room in the result register
  assign take_o = valid_i && (!cls.is_term || out_space_i);

  // acc*10 + digit as (acc<<3) + (acc<<1) + digit, overflow in the top bits
  assign mac = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + (NUM_W+4)'(cls.digit);
  assign ovf = |mac[NUM_W+3:NUM_W];

  assign good = (phase_q == PH_DIGITS) || (phase_q == PH_TRAIL);

  // next phase and accumulator
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    if (take_o) begin
      if (cls.is_term) begin
        phase_d = PH_LEAD;
        acc_d   = '0;
      end else begin
        unique case (phase_q)
          PH_LEAD: begin
            if (cls.is_digit) begin
              phase_d = PH_DIGITS;
              acc_d   = NUM_W'(cls.digit);
            end else if (!cls.is_blank) begin
              phase_d = PH_FAIL;
              acc_d   = '0;
            end
          end
          PH_DIGITS: begin
            if (cls.is_blank) begin
              phase_d = PH_TRAIL;
            end else if (cls.is_digit && !ovf) begin
              acc_d = mac[NUM_W-1:0];
            end else begin
              phase_d = PH_FAIL;
              acc_d   = '0;
            end
          end
          PH_TRAIL: begin
            if (!cls.is_blank) begin
              phase_d = PH_FAIL;
              acc_d   = '0;
            end
          end
          PH_FAIL: begin
            // swallow until terminator
          end
          default: begin
            phase_d = PH_FAIL;
            acc_d   = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      acc_q   <= '0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
    end
  end

  // result on the terminator transfer
  assign res_valid_o  = take_o && cls.is_term;
  assign res_ok_o     = good;
  assign res_number_o = good ? acc_q : '0;

  // accumulator is clear whenever no digits are held
  a_lead_acc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LEAD) |-> (acc_q == '0))
    else $error("accumulator not clear in leading phase");

  a_fail_acc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FAIL) |-> (acc_q == '0))
    else $error("accumulator not clear in failed phase");

  a_term_to_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (phase_q == PH_LEAD))
    else $error("phase not back to leading after terminator");

endmodule

// File: rtl/core/decp_out_stage.sv
// Result register for the decimal parser: holds ok and number until the
// receiver takes them. Depends on decp_pkg.
module decp_out_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic                       ok_i,
  input  logic [decp_pkg::NUM_W-1:0] number_i,
  output logic                       space_o,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic                       ok_o,
  output logic [decp_pkg::NUM_W-1:0] number_o
);
  import decp_pkg::*;

  logic             valid_q, valid_d;
  logic             ok_q;
  logic [NUM_W-1:0] number_q;

  // room when empty or when the held result leaves now
  assign space_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ok_q     <= ok_i;
      number_q <= number_i;
    end
  end

  assign valid_o  = valid_q;
  assign ok_o     = ok_q;
  assign number_o = number_q;

endmodule

// File: rtl/core/decimal_uint64_parser.sv
// ASCII decimal string to 64-bit unsigned value.
// Usage:
//   Input channel (in_valid_i / in_ready_o / character_i) carries one ASCII
//   character per transfer; a zero character ends the string. Leading and
//   trailing spaces or tabs are allowed around the digits. Every other
//   character, or a value past 2^64-1, fails the string.
//   Output channel (out_valid_o / out_ready_i / ok_o / number_o) carries one
//   result per terminator; number_o is zero when ok_o is low.
// Throughput: one character per cycle while no held result blocks a
//   terminator, set by the single parse stage that updates phase and
//   accumulator (shift-and-add times ten) each cycle.
// Path: a terminator goes from the input register to the result register.
// Stall: a held result blocks the next terminator in the input register,
//   and with it the input channel; characters ahead of that terminator keep
//   flowing while the receiver holds off.
// Reset: rst_ni clears the valid flags of both channel registers, returns
//   to the leading-blank phase and clears the accumulator.
// Depends on decp_pkg, decp_in_stage, decp_parse, decp_out_stage.
module decimal_uint64_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 character_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       ok_o,
  output logic [decp_pkg::NUM_W-1:0] number_o
);
  import decp_pkg::*;

  logic             st_valid;
  logic [7:0]       st_char;
  logic             take;
  logic             out_space;
  logic             res_valid;
  logic             res_ok;
  logic [NUM_W-1:0] res_number;

  decp_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .char_i  (character_i),
    .valid_o (st_valid),
    .char_o  (st_char),
    .take_i  (take)
  );

  decp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (st_valid),
    .char_i       (st_char),
    .out_space_i  (out_space),
    .take_o       (take),
    .res_valid_o  (res_valid),
    .res_ok_o     (res_ok),
    .res_number_o (res_number)
  );

  decp_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (res_valid),
    .ok_i     (res_ok),
    .number_i (res_number),
    .space_o  (out_space),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .ok_o     (ok_o),
    .number_o (number_o)
  );

  // a failed string always reports a zero value
  a_fail_number_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (number_o == '0))
    else $error("nonzero number on failed result");

endmodule
